// ===== sv/ciqmu_pkg.sv =====
package ciqmu_pkg;

    // Field widths
    localparam int WORD_W    = 16;
    localparam int SAMPLE_W  = 10;
    localparam int ENTRY_W   = 2 * SAMPLE_W;
    localparam int TONE_W    = 7;
    localparam int STREAM_W  = 2;
    // After an entry is taken at most ENTRY_W-1 bits stay behind
    localparam int ACC_W     = ENTRY_W - 1;
    localparam int HELD_W    = 5;
    localparam int WIDE_W    = ACC_W + WORD_W;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = TONE_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_TONE_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RX_STREAMS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TX_STREAMS = 2'd2;

    // Reset values of the size registers
    localparam logic [TONE_W-1:0]   TONE_COUNT_RST = 7'd56;
    localparam logic [STREAM_W-1:0] RX_STREAMS_RST = 2'd1;
    localparam logic [STREAM_W-1:0] TX_STREAMS_RST = 2'd1;

    typedef struct packed {
        logic [TONE_W-1:0]   tone_count;
        logic [STREAM_W-1:0] rx_streams;
        logic [STREAM_W-1:0] tx_streams;
    } size_cfg_t;

    typedef struct packed {
        logic [ACC_W-1:0]    acc;
        logic [HELD_W-1:0]   held;
        logic [TONE_W-1:0]   tone;
        logic [STREAM_W-1:0] col;
        logic [STREAM_W-1:0] row;
    } unpack_state_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] real_part;
        logic signed [SAMPLE_W-1:0] imag_part;
        logic [TONE_W-1:0]          tone_index;
        logic [STREAM_W-1:0]        column_index;
        logic [STREAM_W-1:0]        row_index;
        logic                       matrix_last;
    } entry_t;

endpackage

// ===== sv/ciqmu_step.sv =====
module ciqmu_step #(
    parameter int MAX_TONES   = 114,
    parameter int MAX_STREAMS = 3
) (
    input  ciqmu_pkg::size_cfg_t     size_cfg,
    input  ciqmu_pkg::unpack_state_t cur,
    input  logic [ciqmu_pkg::WORD_W-1:0] packed_word,
    output ciqmu_pkg::unpack_state_t nxt,
    output ciqmu_pkg::entry_t        entry
);
    import ciqmu_pkg::*;

    localparam logic [TONE_W:0]   TONE_LIMIT   = (TONE_W+1)'(MAX_TONES);
    localparam logic [STREAM_W:0] STREAM_LIMIT = (STREAM_W+1)'(MAX_STREAMS);

    logic [TONE_W:0]   nt;
    logic [STREAM_W:0] nr;
    logic [STREAM_W:0] nc;
    logic [WIDE_W-1:0] wide;
    logic [HELD_W:0]   held_sum;
    logic              have_entry;
    logic [TONE_W:0]   tone_inc;
    logic [STREAM_W:0] col_inc;
    logic [STREAM_W:0] row_inc;
    logic              row_end;
    logic              col_end;
    logic              tone_end;

    // Effective matrix sizes: zero acts as one, large values clamp
    always_comb begin
        nt = {1'b0, size_cfg.tone_count};
        if (nt == '0) begin
            nt = (TONE_W+1)'(1);
        end else if (nt > TONE_LIMIT) begin
            nt = TONE_LIMIT;
        end
        nr = {1'b0, size_cfg.rx_streams};
        if (nr == '0) begin
            nr = (STREAM_W+1)'(1);
        end else if (nr > STREAM_LIMIT) begin
            nr = STREAM_LIMIT;
        end
        nc = {1'b0, size_cfg.tx_streams};
        if (nc == '0) begin
            nc = (STREAM_W+1)'(1);
        end else if (nc > STREAM_LIMIT) begin
            nc = STREAM_LIMIT;
        end
    end

    // Append the word above the bits already held
    assign wide       = {{WORD_W{1'b0}}, cur.acc}
                      | ({{ACC_W{1'b0}}, packed_word} << cur.held);
    assign held_sum   = {1'b0, cur.held} + (HELD_W+1)'(WORD_W);
    assign have_entry = held_sum >= (HELD_W+1)'(ENTRY_W);

    // Index wrap decisions
    assign row_inc  = {1'b0, cur.row} + (STREAM_W+1)'(1);
    assign col_inc  = {1'b0, cur.col} + (STREAM_W+1)'(1);
    assign tone_inc = {1'b0, cur.tone} + (TONE_W+1)'(1);
    assign row_end  = row_inc >= nr;
    assign col_end  = col_inc >= nc;
    assign tone_end = tone_inc >= nt;

    // Result entry
    always_comb begin
        entry.valid        = have_entry;
        entry.imag_part    = wide[SAMPLE_W-1:0];
        entry.real_part    = wide[ENTRY_W-1:SAMPLE_W];
        entry.tone_index   = cur.tone;
        entry.column_index = cur.col;
        entry.row_index    = cur.row;
        entry.matrix_last  = row_end && col_end && tone_end;
    end

    // Next accumulator and counters
    always_comb begin
        nxt = cur;
        if (!have_entry) begin
            nxt.acc  = wide[ACC_W-1:0];
            nxt.held = held_sum[HELD_W-1:0];
        end else begin
            nxt.acc  = ACC_W'(wide[WIDE_W-1:ENTRY_W]);
            nxt.held = HELD_W'(held_sum - (HELD_W+1)'(ENTRY_W));
            if (!row_end) begin
                nxt.row = row_inc[STREAM_W-1:0];
            end else begin
                nxt.row = '0;
                if (!col_end) begin
                    nxt.col = col_inc[STREAM_W-1:0];
                end else begin
                    nxt.col = '0;
                    if (!tone_end) begin
                        nxt.tone = tone_inc[TONE_W-1:0];
                    end else begin
                        // matrix done: leftover bits are dropped
                        nxt.tone = '0;
                        nxt.acc  = '0;
                        nxt.held = '0;
                    end
                end
            end
        end
    end

endmodule

// ===== sv/csi_iq_matrix_unpacker_top.sv =====
// A result appears on m_tvalid in the cycle after the word that completes it is accepted.
// Throughput: one 16-bit word per cycle; in steady flow four of every five words each
// complete one IQ entry, limited only by the output register being taken.
// Reset (aresetn low, synchronous): bit accumulator, counters and output valid clear,
// size registers return to 56 tones, one row, one column.
module csi_iq_matrix_unpacker_top #(
    parameter int MAX_TONES   = 114,
    parameter int MAX_STREAMS = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [ciqmu_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ciqmu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ciqmu_pkg::IN_TDATA_W-1:0]    s_tdata,  // [15:0] packed_word
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [9:0] real_part, [19:10] imag_part, [26:20] tone_index,
    // [28:27] column_index, [30:29] row_index, [31] zero
    output logic [ciqmu_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                m_tlast   // matrix_last
);
    import ciqmu_pkg::*;

    size_cfg_t     size_reg;
    unpack_state_t state_reg;
    unpack_state_t state_next;
    entry_t        entry;
    logic          m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic          m_tlast_reg;
    logic          s_accept;

    // Size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg.tone_count <= TONE_COUNT_RST;
            size_reg.rx_streams <= RX_STREAMS_RST;
            size_reg.tx_streams <= TX_STREAMS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_TONE_COUNT: size_reg.tone_count <= cfg_wdata;
                CFG_RX_STREAMS: size_reg.rx_streams <= cfg_wdata[STREAM_W-1:0];
                CFG_TX_STREAMS: size_reg.tx_streams <= cfg_wdata[STREAM_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack datapath
    ciqmu_step #(
        .MAX_TONES   (MAX_TONES),
        .MAX_STREAMS (MAX_STREAMS)
    ) u_step (
        .size_cfg    (size_reg),
        .cur         (state_reg),
        .packed_word (s_tdata[WORD_W-1:0]),
        .nxt         (state_next),
        .entry       (entry)
    );

    // Take a request whenever the output register is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // Accumulator and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= entry.valid;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && entry.valid) begin
            m_tdata_reg <= {1'b0, entry.row_index, entry.column_index, entry.tone_index,
                            entry.imag_part, entry.real_part};
            m_tlast_reg <= entry.matrix_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== sim/csi_iq_unpack_checker.sv =====
`timescale 1ns / 100ps

module csi_iq_unpack_checker #(
    parameter int TONE_LIMIT   = 114,
    parameter int STREAM_LIMIT = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ciqmu_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ciqmu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [ciqmu_pkg::IN_TDATA_W-1:0]    s_tdata,  // [15:0] packed_word
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // [9:0] real_part, [19:10] imag_part, [26:20] tone_index,
    // [28:27] column_index, [30:29] row_index, [31] zero
    input  logic [ciqmu_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                                m_tlast,  // matrix_last
    output int                                  fail_count,
    output int                                  pending
);
    import ciqmu_pkg::*;

    typedef struct {
        logic [SAMPLE_W-1:0] re;
        logic [SAMPLE_W-1:0] im;
        logic [TONE_W-1:0]   tone;
        logic [STREAM_W-1:0] col;
        logic [STREAM_W-1:0] row;
        logic                last;
    } iq_entry_t;

    iq_entry_t           entry_q[$];

    // shadow copy of the size registers
    logic [TONE_W-1:0]   tone_cfg;
    logic [STREAM_W-1:0] rx_cfg;
    logic [STREAM_W-1:0] tx_cfg;

    // shadow copy of the unpacker state
    logic [34:0]         acc;
    logic [5:0]          held;
    logic [TONE_W-1:0]   tone_cnt;
    logic [STREAM_W-1:0] col_cnt;
    logic [STREAM_W-1:0] row_cnt;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int clamp_size(int v, int lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    // append one word and queue the entry it completes, if any
    function automatic void unpack_word(logic [WORD_W-1:0] word);
        iq_entry_t   e;
        int          nt;
        int          nr;
        int          nc;
        logic        row_end;
        logic        col_end;
        logic        tone_end;
        logic [63:0] wide;

        nt   = clamp_size(int'(tone_cfg), TONE_LIMIT);
        nr   = clamp_size(int'(rx_cfg), STREAM_LIMIT);
        nc   = clamp_size(int'(tx_cfg), STREAM_LIMIT);
        wide = 64'(word) << held[4:0];
        acc  = acc | wide[34:0];
        held = held + 6'd16;
        if (held < 6'd20)
            return;

        // imaginary part comes first in the bit stream
        e.im = acc[9:0];
        e.re = acc[19:10];
        acc  = acc >> 20;
        held = held - 6'd20;

        row_end  = (int'(row_cnt) + 1) >= nr;
        col_end  = (int'(col_cnt) + 1) >= nc;
        tone_end = (int'(tone_cnt) + 1) >= nt;

        e.tone = tone_cnt;
        e.col  = col_cnt;
        e.row  = row_cnt;
        e.last = row_end && col_end && tone_end;
        entry_q.push_back(e);

        // row fastest, then column, then tone; matrix end clears everything
        if (!row_end) begin
            row_cnt = row_cnt + 2'd1;
        end else begin
            row_cnt = '0;
            if (!col_end) begin
                col_cnt = col_cnt + 2'd1;
            end else begin
                col_cnt = '0;
                if (!tone_end) begin
                    tone_cnt = tone_cnt + 7'd1;
                end else begin
                    tone_cnt = '0;
                    acc      = '0;
                    held     = '0;
                end
            end
        end
    endfunction

    function automatic void compare_field(string name, int expv, int actv);
        if (expv != actv) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        iq_entry_t e;
        if (!aresetn) begin
            tone_cfg = TONE_COUNT_RST;
            rx_cfg   = RX_STREAMS_RST;
            tx_cfg   = TX_STREAMS_RST;
            acc      = '0;
            held     = '0;
            tone_cnt = '0;
            col_cnt  = '0;
            row_cnt  = '0;
            entry_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_TONE_COUNT: tone_cfg = cfg_wdata[TONE_W-1:0];
                    CFG_RX_STREAMS: rx_cfg = cfg_wdata[STREAM_W-1:0];
                    CFG_TX_STREAMS: tx_cfg = cfg_wdata[STREAM_W-1:0];
                    default: ;
                endcase
            end

            // result request: compare with the oldest queued entry
            if (m_tvalid && m_tready) begin
                if (entry_q.size() == 0) begin
                    $error("unexpected result: tdata %h, tlast %b", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    e = entry_q.pop_front();
                    compare_field("real_part", int'($signed(e.re)),
                                  int'($signed(m_tdata[9:0])));
                    compare_field("imag_part", int'($signed(e.im)),
                                  int'($signed(m_tdata[19:10])));
                    compare_field("tone_index", int'(e.tone), int'(m_tdata[26:20]));
                    compare_field("column_index", int'(e.col), int'(m_tdata[28:27]));
                    compare_field("row_index", int'(e.row), int'(m_tdata[30:29]));
                    compare_field("tdata_pad", 0, int'(m_tdata[31]));
                    compare_field("matrix_last", int'(e.last), int'(m_tlast));
                end
            end

            if (s_tvalid && s_tready)
                unpack_word(s_tdata);
        end
        pending = entry_q.size();
    end

endmodule

// ===== sim/tb_csi_iq_matrix_unpacker_top.sv =====
`timescale 1ns / 100ps

module tb_csi_iq_matrix_unpacker_top;
    import ciqmu_pkg::*;

    localparam int MAX_TONES    = 114;
    localparam int MAX_STREAMS  = 3;
    localparam int ITEMS_PER_PH = 110;
    localparam int NUM_PHASES   = 8;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_ADDR = 2'd3;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;   // [15:0] packed_word
    logic                    m_tvalid;
    logic                    m_tready;
    // [9:0] real_part, [19:10] imag_part, [26:20] tone_index,
    // [28:27] column_index, [30:29] row_index, [31] zero
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tlast;   // matrix_last

    int                      fail_count;
    int                      pending;
    int                      src_idle;
    int                      sink_stall;
    int                      hold_req;
    int                      hold_seen;
    int                      hold_left;
    int                      quiet_cycles;

    csi_iq_matrix_unpacker_top #(
        .MAX_TONES   (MAX_TONES),
        .MAX_STREAMS (MAX_STREAMS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    csi_iq_unpack_checker #(
        .TONE_LIMIT   (MAX_TONES),
        .STREAM_LIMIT (MAX_STREAMS)
    ) i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= sink_stall);
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // offer one word, with random gaps before it
    task automatic push_word(logic [WORD_W-1:0] word);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // stop sending and let every queued result drain out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // leaves cfg_wr_en high; the caller lowers it after the last write
    task automatic write_size_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic set_sizes(int tones, int rows, int cols);
        wait_drained();
        write_size_reg(CFG_TONE_COUNT, CFG_DATA_W'(tones));
        write_size_reg(CFG_RX_STREAMS, CFG_DATA_W'(rows));
        write_size_reg(CFG_TX_STREAMS, CFG_DATA_W'(cols));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [WORD_W-1:0] directed_words [16];
        int                tones;
        int                rows;
        int                cols;

        directed_words = '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h0001,
                           16'h7FFF, 16'hFE00, 16'h0007, 16'h01FF, 16'h0008, 16'h5555,
                           16'hAAAA, 16'h0200, 16'hFDFF, 16'hFFFF};

        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        src_idle   = 0;
        sink_stall = 0;
        hold_req   = 0;
        hold_seen  = 0;
        hold_left  = 0;
        quiet_cycles = 0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes at the reset sizes
        foreach (directed_words[i])
            push_word(directed_words[i]);

        // shrink the tone count below the running tone: next entry ends the matrix
        wait_drained();
        write_size_reg(CFG_TONE_COUNT, '0);
        cfg_wr_en <= 1'b0;
        repeat (5) push_word(rand_word());

        // unused register index is ignored; zero stream counts act as one
        wait_drained();
        write_size_reg(CFG_SPARE_ADDR, 7'h7F);
        write_size_reg(CFG_RX_STREAMS, '0);
        write_size_reg(CFG_TX_STREAMS, '0);
        cfg_wr_en <= 1'b0;
        repeat (5) push_word(rand_word());

        // random phases over sizes and idle patterns
        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            case (ph % 4)
                0:       begin src_idle = 0;  sink_stall = 0;  end
                1:       begin src_idle = 51; sink_stall = 0;  end
                2:       begin src_idle = 0;  sink_stall = 51; end
                default: begin src_idle = 19; sink_stall = 19; end
            endcase
            case (ph)
                1: begin tones = MAX_TONES; rows = 1; cols = 1; end
                2: begin tones = 127;       rows = 3; cols = 3; end
                3: begin tones = 1;         rows = 3; cols = 0; end
                4: begin tones = 2;         rows = 2; cols = 3; end
                default: begin
                    tones = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                        : $urandom_range(0, 6);
                    rows  = $urandom_range(0, 3);
                    cols  = $urandom_range(0, 3);
                end
            endcase
            set_sizes(tones, rows, cols);
            for (int i = 0; i < ITEMS_PER_PH; i++) begin
                // long receiver hold-off while the sender keeps offering
                if (ph == 4 && i == 5)
                    hold_req++;
                push_word(rand_word());
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ciqmu_pkg.sv
sv/ciqmu_step.sv
sv/csi_iq_matrix_unpacker_top.sv
sim/csi_iq_unpack_checker.sv
sim/tb_csi_iq_matrix_unpacker_top.sv
